[rtl/frame_dirty_rectangle_core_defines.svh]
// assertion macros for the frame dirty rectangle core
// no dependencies; included by the checker file
`ifndef FRAME_DIRTY_RECTANGLE_CORE_DEFINES_SVH
`define FRAME_DIRTY_RECTANGLE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define FDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fdr_pkg.sv]
// shared types and constants of the frame dirty rectangle core
// no dependencies; used by every rtl module
`default_nettype none

package fdr_pkg;

    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int MAX_HEIGHT_DEF     = 1024;
    localparam int UNCHANGED_ROWS_DEF = 4;

    localparam int CFG_W     = 11;
    localparam int FIELD_W   = 11;
    localparam int PIX_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    typedef enum logic [1:0] {
        KIND_FIRST     = 2'd0,
        KIND_UNCHANGED = 2'd1,
        KIND_WHOLE     = 2'd2,
        KIND_PARTIAL   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [FIELD_W-1:0] left;
        logic [FIELD_W-1:0] top;
        logic [FIELD_W-1:0] right;
        logic [FIELD_W-1:0] bottom;
        t_kind              kind;
    } t_rect;

    // pixel slot control travelling into the compare stage
    typedef struct packed {
        logic valid;
        logic last;
    } t_px_ctrl;

endpackage

`default_nettype wire

[rtl/fdr_frame_store.sv]
// previous-frame pixel store, one access per cycle
// depends on fdr_pkg for the pixel width
`default_nettype none

module fdr_frame_store #(
    parameter int DEPTH = fdr_pkg::MAX_WIDTH_DEF * fdr_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [$clog2(DEPTH)-1:0]    i_addr,
    input  wire logic [fdr_pkg::PIX_W-1:0]   i_wr_data,
    output logic      [fdr_pkg::PIX_W-1:0]   o_rd_data
);

    logic [fdr_pkg::PIX_W-1:0] mem [DEPTH];
    logic [fdr_pkg::PIX_W-1:0] r_rd_data;

    // read-first: the old pixel comes out while the new one goes in
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data    <= mem[i_addr];
            mem[i_addr]  <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/fdr_box_tracker.sv]
// compare stage: pixel difference, bounding box update and frame result
// depends on fdr_pkg for t_rect, t_kind and t_px_ctrl
`default_nettype none

module fdr_box_tracker #(
    parameter int MAX_WIDTH      = fdr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = fdr_pkg::MAX_HEIGHT_DEF,
    parameter int UNCHANGED_ROWS = fdr_pkg::UNCHANGED_ROWS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_restart,
    input  wire fdr_pkg::t_px_ctrl                   i_ctrl,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]        i_x,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0]       i_y,
    input  wire logic [fdr_pkg::PIX_W-1:0]           i_pix,
    input  wire logic [fdr_pkg::PIX_W-1:0]           i_rd_data,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      i_eff_w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]     i_eff_h,
    output logic                                     o_push,
    output fdr_pkg::t_rect                           o_rect
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int BW = $clog2(MAX_WIDTH + 1);
    localparam int BH = $clog2(MAX_HEIGHT + 1);
    localparam int FW = fdr_pkg::FIELD_W;

    fdr_pkg::t_px_ctrl          r_ctrl;
    logic [XW-1:0]              r_x;
    logic [YW-1:0]              r_y;
    logic [fdr_pkg::PIX_W-1:0]  r_pix;
    logic                       r_have_prev;
    logic [BW-1:0]              r_min_x, n_min_x;
    logic [BW-1:0]              r_end_x, n_end_x;
    logic [BH-1:0]              r_min_y, n_min_y;
    logic [BH-1:0]              r_end_y, n_end_y;

    logic [BW-1:0]              w_x;
    logic [BW-1:0]              w_x1;
    logic [BH-1:0]              w_y;
    logic [BH-1:0]              w_y1;
    logic                       w_diff;
    logic [BH-1:0]              w_unch_rows;

    assign w_x    = BW'(r_x);
    assign w_x1   = w_x + BW'(1);
    assign w_y    = BH'(r_y);
    assign w_y1   = w_y + BH'(1);
    assign w_diff = r_have_prev && (i_rd_data != r_pix);

    always_comb begin
        n_min_x = r_min_x;
        n_end_x = r_end_x;
        n_min_y = r_min_y;
        n_end_y = r_end_y;
        if (w_diff) begin
            if (w_x < r_min_x) n_min_x = w_x;
            if (w_x1 > r_end_x) n_end_x = w_x1;
            if (w_y < r_min_y) n_min_y = w_y;
            if (w_y1 > r_end_y) n_end_y = w_y1;
        end
    end

    assign w_unch_rows = (UNCHANGED_ROWS > i_eff_h) ? i_eff_h : BH'(UNCHANGED_ROWS);

    always_comb begin
        o_rect.left   = '0;
        o_rect.top    = '0;
        o_rect.right  = FW'(i_eff_w);
        o_rect.bottom = FW'(i_eff_h);
        priority if (!r_have_prev) begin
            o_rect.kind = fdr_pkg::KIND_FIRST;
        end else if (n_end_y == '0) begin
            o_rect.kind   = fdr_pkg::KIND_UNCHANGED;
            o_rect.bottom = FW'(w_unch_rows);
        end else if (n_min_x == '0 && n_min_y == '0 &&
                     n_end_x == i_eff_w && n_end_y == i_eff_h) begin
            o_rect.kind = fdr_pkg::KIND_WHOLE;
        end else begin
            o_rect.kind   = fdr_pkg::KIND_PARTIAL;
            o_rect.left   = FW'(n_min_x);
            o_rect.top    = FW'(n_min_y);
            o_rect.right  = FW'(n_end_x);
            o_rect.bottom = FW'(n_end_y);
        end
    end

    assign o_push = r_ctrl.valid && r_ctrl.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_ctrl      <= '0;
            r_have_prev <= 1'b0;
            r_min_x     <= '1;
            r_end_x     <= '0;
            r_min_y     <= '1;
            r_end_y     <= '0;
        end else begin
            r_ctrl <= i_ctrl;
            if (r_ctrl.valid) begin
                if (r_ctrl.last) begin
                    r_have_prev <= 1'b1;
                    r_min_x     <= '1;
                    r_end_x     <= '0;
                    r_min_y     <= '1;
                    r_end_y     <= '0;
                end else begin
                    r_min_x <= n_min_x;
                    r_end_x <= n_end_x;
                    r_min_y <= n_min_y;
                    r_end_y <= n_end_y;
                end
            end
        end
    end

    // payload of the compare stage
    always_ff @(posedge i_clk) begin
        r_x   <= i_x;
        r_y   <= i_y;
        r_pix <= i_pix;
    end

endmodule

`default_nettype wire

[rtl/fdr_result_fifo.sv]
// two-entry result queue between the compare stage and the output port
// depends on fdr_pkg for t_rect
`default_nettype none

module fdr_result_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fdr_pkg::t_rect  i_data,
    input  wire logic            i_ready,
    output logic                 o_valid,
    output fdr_pkg::t_rect       o_data,
    output logic [1:0]           o_count
);

    fdr_pkg::t_rect r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

`default_nettype wire

[rtl/frame_dirty_rectangle_core.sv]
// top level of the frame dirty rectangle core
// depends on fdr_pkg, fdr_frame_store, fdr_box_tracker and fdr_result_fifo

// Takes 24-bit RGB pixels in raster order, one transfer per clock at full rate,
// compares each with the same position of the previous frame held in an
// on-chip frame store (MAX_WIDTH*MAX_HEIGHT words, no clearing pass, usable
// straight after reset) and, at the last pixel of each frame, gives one
// rectangle transfer with its kind: first frame, unchanged, whole frame changed
// or partial. The rate of one pixel per cycle is set by the frame store, which
// does one read-and-overwrite per cycle. A result is offered once its last pixel
// has been compared and queued. Results wait in a two-entry queue; pixel ready
// drops only while that queue and the compare stage together hold two unread results.
// Writing frame_width or frame_height (only while the block is idle) drops the
// frame in progress and makes the next frame a first frame.
`default_nettype none

module frame_dirty_rectangle_core #(
    parameter int MAX_WIDTH      = fdr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = fdr_pkg::MAX_HEIGHT_DEF,
    parameter int UNCHANGED_ROWS = fdr_pkg::UNCHANGED_ROWS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [fdr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fdr_pkg::CFG_W-1:0]       i_cfg_data,
    // pixel channel
    input  wire logic                            i_pix_valid,
    output logic                                 o_pix_ready,
    input  wire logic [fdr_pkg::PIX_W-1:0]       i_pixel_rgb,
    // result channel
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output logic [fdr_pkg::FIELD_W-1:0]          o_rect_left,
    output logic [fdr_pkg::FIELD_W-1:0]          o_rect_top,
    output logic [fdr_pkg::FIELD_W-1:0]          o_rect_right,
    output logic [fdr_pkg::FIELD_W-1:0]          o_rect_bottom,
    output logic [1:0]                           o_frame_kind
);

    localparam int XW       = $clog2(MAX_WIDTH);
    localparam int YW       = $clog2(MAX_HEIGHT);
    localparam int BW       = $clog2(MAX_WIDTH + 1);
    localparam int BH       = $clog2(MAX_HEIGHT + 1);
    localparam int FS_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = $clog2(FS_DEPTH);

    // configuration registers
    logic [fdr_pkg::CFG_W-1:0] r_frame_width;
    logic [fdr_pkg::CFG_W-1:0] r_frame_height;
    logic                      w_cfg_hit;

    // saturated frame size
    logic [BW-1:0] w_eff_w;
    logic [BH-1:0] w_eff_h;

    // raster position of the next pixel; row base is row*MAX_WIDTH
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [AW-1:0] r_row_base;
    logic [AW-1:0] w_addr;
    logic          w_col_last;
    logic          w_row_last;
    logic          w_frame_last;
    logic          w_acc;

    fdr_pkg::t_px_ctrl         w_ctrl;
    logic [fdr_pkg::PIX_W-1:0] w_rd_data;
    logic                      w_push;
    fdr_pkg::t_rect            w_rect;
    fdr_pkg::t_rect            w_out;
    logic [1:0]                w_count;
    logic                      w_pop;
    logic [2:0]                w_occ;

    assign w_cfg_hit = i_cfg_we && (i_cfg_idx == fdr_pkg::REG_FRAME_WIDTH ||
                                    i_cfg_idx == fdr_pkg::REG_FRAME_HEIGHT);

    // saturate to 1..MAX
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff_w = BW'(1);
        end else if (r_frame_width > MAX_WIDTH) begin
            w_eff_w = BW'(MAX_WIDTH);
        end else begin
            w_eff_w = BW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            w_eff_h = BH'(1);
        end else if (r_frame_height > MAX_HEIGHT) begin
            w_eff_h = BH'(MAX_HEIGHT);
        end else begin
            w_eff_h = BH'(r_frame_height);
        end
    end

    assign w_col_last   = (BW'(r_col) + BW'(1)) == w_eff_w;
    assign w_row_last   = (BH'(r_row) + BH'(1)) == w_eff_h;
    assign w_frame_last = w_col_last && w_row_last;
    assign w_addr       = r_row_base + AW'(r_col);

    // room for the result of a pixel taken now: queue plus compare stage, less a read
    assign w_pop       = o_res_valid && i_res_ready;
    assign w_occ       = 3'(w_count) + 3'(w_push);
    assign o_pix_ready = w_occ <= (3'd1 + 3'(w_pop));
    assign w_acc       = i_pix_valid && o_pix_ready;

    assign w_ctrl.valid = w_acc;
    assign w_ctrl.last  = w_frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= fdr_pkg::FRAME_WIDTH_RST;
            r_frame_height <= fdr_pkg::FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_row_base     <= '0;
        end else if (w_cfg_hit) begin
            // a size change restarts the raster
            if (i_cfg_idx == fdr_pkg::REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end else begin
                r_frame_height <= i_cfg_data;
            end
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
        end else if (w_acc) begin
            priority if (w_frame_last) begin
                r_col      <= '0;
                r_row      <= '0;
                r_row_base <= '0;
            end else if (w_col_last) begin
                r_col      <= '0;
                r_row      <= r_row + YW'(1);
                r_row_base <= r_row_base + AW'(MAX_WIDTH);
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    // read the old pixel and store the new one in the same access
    fdr_frame_store #(
        .DEPTH (FS_DEPTH)
    ) u_frame_store (
        .i_clk     (i_clk),
        .i_en      (w_acc),
        .i_addr    (w_addr),
        .i_wr_data (i_pixel_rgb),
        .o_rd_data (w_rd_data)
    );

    // compare stage, working in the cycle after the store access
    fdr_box_tracker #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .UNCHANGED_ROWS (UNCHANGED_ROWS)
    ) u_box_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_cfg_hit),
        .i_ctrl    (w_ctrl),
        .i_x       (r_col),
        .i_y       (r_row),
        .i_pix     (i_pixel_rgb),
        .i_rd_data (w_rd_data),
        .i_eff_w   (w_eff_w),
        .i_eff_h   (w_eff_h),
        .o_push    (w_push),
        .o_rect    (w_rect)
    );

    fdr_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rect),
        .i_ready (i_res_ready),
        .o_valid (o_res_valid),
        .o_data  (w_out),
        .o_count (w_count)
    );

    assign o_rect_left   = w_out.left;
    assign o_rect_top    = w_out.top;
    assign o_rect_right  = w_out.right;
    assign o_rect_bottom = w_out.bottom;
    assign o_frame_kind  = w_out.kind;

endmodule

`default_nettype wire

[rtl/fdr_checker.sv]
// port-level checks of the frame dirty rectangle core, bound to the top level
// depends on fdr_pkg and frame_dirty_rectangle_core_defines.svh
`default_nettype none
`include "frame_dirty_rectangle_core_defines.svh"

module fdr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_pix_valid,
    input wire logic                            o_pix_ready,
    input wire logic [fdr_pkg::PIX_W-1:0]       i_pixel_rgb,
    input wire logic                            o_res_valid,
    input wire logic                            i_res_ready,
    input wire logic [fdr_pkg::FIELD_W-1:0]     o_rect_left,
    input wire logic [fdr_pkg::FIELD_W-1:0]     o_rect_top,
    input wire logic [fdr_pkg::FIELD_W-1:0]     o_rect_right,
    input wire logic [fdr_pkg::FIELD_W-1:0]     o_rect_bottom,
    input wire logic [1:0]                      o_frame_kind
);

    // nothing in flight straight after reset
    `FDR_ASSERT_IMP(a_clean_after_reset, i_clk, i_rst_n, !$past(i_rst_n),
        o_pix_ready && !o_res_valid, "core not empty after reset")

    // every rectangle is non-empty with ordered edges
    `FDR_ASSERT_IMP(a_rect_ordered, i_clk, i_rst_n, o_res_valid,
        (o_rect_left < o_rect_right) && (o_rect_top < o_rect_bottom),
        "result rectangle empty or inverted")

    // first-frame, full-frame and unchanged kinds start at the origin
    `FDR_ASSERT_IMP(a_origin_kinds, i_clk, i_rst_n,
        o_res_valid && o_frame_kind != fdr_pkg::KIND_PARTIAL,
        o_rect_left == '0 && o_rect_top == '0, "non-partial result off origin")

    // a stalled result holds
    `FDR_ASSERT_NXT(a_result_held, i_clk, i_rst_n, o_res_valid && !i_res_ready,
        o_res_valid && $stable(o_rect_left) && $stable(o_rect_top) &&
        $stable(o_rect_right) && $stable(o_rect_bottom) && $stable(o_frame_kind),
        "stalled result changed")

    // a pixel offer holds until taken
    `FDR_ASSERT_NXT(a_pix_held, i_clk, i_rst_n, i_pix_valid && !o_pix_ready,
        i_pix_valid && $stable(i_pixel_rgb), "pixel offer dropped or changed")

endmodule

bind frame_dirty_rectangle_core fdr_checker u_fdr_checker (.*);

`default_nettype wire

[bench/frame_dirty_rectangle_core_tb.sv]
`timescale 1ns / 100ps
// self-checking bench for the frame dirty rectangle core: frames of pixels in, rectangles out
// depends on fdr_pkg and frame_dirty_rectangle_core; needs nothing else to run

module frame_dirty_rectangle_core_tb;

    localparam int MAX_W     = fdr_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H     = fdr_pkg::MAX_HEIGHT_DEF;
    localparam int TOP_ROWS  = fdr_pkg::UNCHANGED_ROWS_DEF;
    localparam int IDLE_PCT  = 24;
    localparam int HOLD_LEN  = 300;
    localparam int SETTLE    = 8;

    // register indexes past the two real ones, which the block must ignore
    localparam logic [fdr_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [fdr_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // how the stimulus builds a frame from the one sent before it
    typedef enum int {
        FR_RANDOM,
        FR_EXTREME,
        FR_COPY,
        FR_SPARSE,
        FR_ALL,
        FR_CORNERS,
        FR_ROW0
    } t_frame_style;

    // ---------------------------------------------------------------
    // block inputs, all known from time zero
    // ---------------------------------------------------------------
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [fdr_pkg::CFG_IDX_W-1:0] i_cfg_idx   = fdr_pkg::REG_FRAME_WIDTH;
    logic [fdr_pkg::CFG_W-1:0]     i_cfg_data  = '0;
    logic                          i_pix_valid = 1'b0;
    logic [fdr_pkg::PIX_W-1:0]     i_pixel_rgb = '0;
    logic                          i_res_ready = 1'b0;

    logic                          o_pix_ready;
    logic                          o_res_valid;
    logic [fdr_pkg::FIELD_W-1:0]   o_rect_left;
    logic [fdr_pkg::FIELD_W-1:0]   o_rect_top;
    logic [fdr_pkg::FIELD_W-1:0]   o_rect_right;
    logic [fdr_pkg::FIELD_W-1:0]   o_rect_bottom;
    logic [1:0]                    o_frame_kind;

    frame_dirty_rectangle_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pix_valid   (i_pix_valid),
        .o_pix_ready   (o_pix_ready),
        .i_pixel_rgb   (i_pixel_rgb),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_rect_left   (o_rect_left),
        .o_rect_top    (o_rect_top),
        .o_rect_right  (o_rect_right),
        .o_rect_bottom (o_rect_bottom),
        .o_frame_kind  (o_frame_kind)
    );

    // ---------------------------------------------------------------
    // shared bench state
    // ---------------------------------------------------------------
    logic [fdr_pkg::PIX_W-1:0] pixel_backlog [$];   // pixels waiting for the driver
    fdr_pkg::t_rect            expected_rects [$];  // rectangles predicted, not yet seen
    int               errors       = 0;
    bit               pix_taken    = 1'b0; // transfer at the last rising edge
    int               pix_idle_pct = IDLE_PCT;
    int               res_idle_pct = IDLE_PCT;
    int               hold_req     = 0;    // bumped to ask for a long receiver hold-off
    int               hold_ack     = 0;
    int               hold_left    = 0;

    // predictor copy of the block's registers and frame tracking
    logic [fdr_pkg::CFG_W-1:0] pred_width  = fdr_pkg::FRAME_WIDTH_RST;
    logic [fdr_pkg::CFG_W-1:0] pred_height = fdr_pkg::FRAME_HEIGHT_RST;
    bit                        pred_have   = 1'b0;
    int                        pred_col, pred_row;
    int                        box_x0, box_x1, box_y0, box_y1;
    logic [fdr_pkg::PIX_W-1:0] stored_frame [int];
    fdr_pkg::t_rect            want;

    // stimulus side view of the frame geometry and the last frame sent
    int                        gen_w    = 640;
    int                        gen_h    = 480;
    bit                        gen_have = 1'b0;
    logic [fdr_pkg::PIX_W-1:0] sent_frame [int];

    // ---------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------
    // register value saturated into the legal geometry range
    function automatic int clamp_dim(input logic [fdr_pkg::CFG_W-1:0] v, input int lim);
        if (v < 1) return 1;
        if (v > lim) return lim;
        return int'(v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        errors++;
        if (errors <= 50)
            $display("mismatch: %s got %0d wanted %0d", what, got, exp_val);
    endtask

    // box restarts empty, min edges parked at the far side
    task automatic restart_box();
        pred_col = 0;
        pred_row = 0;
        box_x0   = clamp_dim(pred_width, MAX_W);
        box_x1   = 0;
        box_y0   = clamp_dim(pred_height, MAX_H);
        box_y1   = 0;
    endtask

    task automatic apply_reg_write(input logic [fdr_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [fdr_pkg::CFG_W-1:0] data);
        if (idx == fdr_pkg::REG_FRAME_WIDTH) begin
            pred_width = data;
        end else if (idx == fdr_pkg::REG_FRAME_HEIGHT) begin
            pred_height = data;
        end else begin
            return;
        end
        // any real write drops the frame in flight and forgets the stored one
        pred_have = 1'b0;
        restart_box();
    endtask

    // compare one pixel with the stored frame, grow the box, emit at frame end
    task automatic fold_pixel(input logic [fdr_pkg::PIX_W-1:0] px);
        int             w, h, x, y, addr, rows;
        fdr_pkg::t_rect r;
        w = clamp_dim(pred_width, MAX_W);
        h = clamp_dim(pred_height, MAX_H);
        x = (pred_col >= w) ? w - 1 : pred_col;
        y = (pred_row >= h) ? h - 1 : pred_row;
        addr = y * MAX_W + x;
        if (pred_have && stored_frame[addr] != px) begin
            if (x < box_x0) box_x0 = x;
            if (x + 1 > box_x1) box_x1 = x + 1;
            if (y < box_y0) box_y0 = y;
            if (y + 1 > box_y1) box_y1 = y + 1;
        end
        stored_frame[addr] = px;
        if (!(x == w - 1 && y == h - 1)) begin
            if (x == w - 1) begin
                pred_col = 0;
                pred_row = y + 1;
            end else begin
                pred_col = x + 1;
                pred_row = y;
            end
            return;
        end
        r.left = '0;
        r.top  = '0;
        r.right  = fdr_pkg::FIELD_W'(w);
        r.bottom = fdr_pkg::FIELD_W'(h);
        if (!pred_have) begin
            r.kind = fdr_pkg::KIND_FIRST;
        end else if (box_y1 == 0) begin
            // nothing differed: report only the top rows
            rows     = (TOP_ROWS > h) ? h : TOP_ROWS;
            r.bottom = fdr_pkg::FIELD_W'(rows);
            r.kind   = fdr_pkg::KIND_UNCHANGED;
        end else if (box_x0 == 0 && box_y0 == 0 && box_x1 == w && box_y1 == h) begin
            r.kind = fdr_pkg::KIND_WHOLE;
        end else begin
            r.left   = fdr_pkg::FIELD_W'(box_x0);
            r.top    = fdr_pkg::FIELD_W'(box_y0);
            r.right  = fdr_pkg::FIELD_W'(box_x1);
            r.bottom = fdr_pkg::FIELD_W'(box_y1);
            r.kind   = fdr_pkg::KIND_PARTIAL;
        end
        expected_rects.push_back(r);
        pred_have = 1'b1;
        restart_box();
    endtask

    function automatic int img_addr(input int i);
        return (i / gen_w) * MAX_W + (i % gen_w);
    endfunction

    // non-zero xor pattern, so a flipped pixel always differs
    function automatic logic [fdr_pkg::PIX_W-1:0] flip_mask();
        logic [fdr_pkg::PIX_W-1:0] m;
        m = fdr_pkg::PIX_W'($urandom);
        if (m == '0) m = fdr_pkg::PIX_W'(1);
        return m;
    endfunction

    function automatic t_frame_style pick_style();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return FR_COPY;
        if (r < 55) return FR_SPARSE;
        if (r < 65) return FR_ALL;
        if (r < 75) return FR_CORNERS;
        if (r < 90) return FR_ROW0;
        return FR_RANDOM;
    endfunction

    // build a frame, for most styles from the last one sent, and queue its first cut pixels
    task automatic queue_frame(input t_frame_style style, input int cut);
        int                        n, k, pos;
        logic [fdr_pkg::PIX_W-1:0] frm [$];
        t_frame_style              s;
        s = style;
        n = gen_w * gen_h;
        // without a complete earlier frame there is nothing to copy from
        if (!gen_have && s != FR_EXTREME) s = FR_RANDOM;
        for (int i = 0; i < n; i++) begin
            case (s)
                FR_RANDOM:  frm.push_back(fdr_pkg::PIX_W'($urandom));
                FR_EXTREME: frm.push_back((i % 2 == 1) ? 24'hFFFFFF : 24'h000000);
                FR_ALL:     frm.push_back(sent_frame[img_addr(i)] ^ flip_mask());
                default:    frm.push_back(sent_frame[img_addr(i)]);
            endcase
        end
        case (s)
            FR_SPARSE: begin
                k = $urandom_range(1, 3);
                repeat (k) begin
                    pos = $urandom_range(0, n - 1);
                    frm[pos] ^= flip_mask();
                end
            end
            FR_CORNERS: begin
                // first and last pixel together span the whole frame
                frm[0] ^= flip_mask();
                if (n > 1) frm[n-1] ^= flip_mask();
            end
            FR_ROW0: begin
                k = $urandom_range(1, 2);
                repeat (k) begin
                    pos = $urandom_range(0, gen_w - 1);
                    frm[pos] ^= flip_mask();
                end
            end
            default: ;
        endcase
        for (int i = 0; i < cut; i++) begin
            pixel_backlog.push_back(frm[i]);
            sent_frame[img_addr(i)] = frm[i];
        end
        if (cut == n) gen_have = 1'b1;
    endtask

    // everything sent, everything delivered, then let the pipeline drain
    task automatic wait_idle();
        while (pixel_backlog.size() != 0 || i_pix_valid || expected_rects.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fdr_pkg::CFG_IDX_W-1:0] idx, input int value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = fdr_pkg::CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == fdr_pkg::REG_FRAME_WIDTH) begin
            gen_w    = clamp_dim(fdr_pkg::CFG_W'(value), MAX_W);
            gen_have = 1'b0;
        end else if (idx == fdr_pkg::REG_FRAME_HEIGHT) begin
            gen_h    = clamp_dim(fdr_pkg::CFG_W'(value), MAX_H);
            gen_have = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // clock and run limit
    // ---------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // far beyond the slowest legal run, including the long receiver hold-off
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------
    // pixel driver: holds each transfer until taken, idles at random
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pix_valid <= 1'b0;
        end else if (i_pix_valid && !pix_taken) begin
            // offer stays up with the same pixel until the transfer happens
            i_pix_valid <= 1'b1;
        end else if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= pix_idle_pct) begin
            i_pix_valid <= 1'b1;
            i_pixel_rgb <= pixel_backlog.pop_front();
        end else begin
            i_pix_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // result receiver: random back-pressure plus one long hold-off on request
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= ($urandom_range(0, 99) >= res_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: register writes and pixel transfers feed the predictor,
    // result transfers are checked against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pred_width  = fdr_pkg::FRAME_WIDTH_RST;
            pred_height = fdr_pkg::FRAME_HEIGHT_RST;
            pred_have   = 1'b0;
            restart_box();
            pix_taken   = 1'b0;
        end else begin
            if (i_cfg_we) apply_reg_write(i_cfg_idx, i_cfg_data);
            if (o_res_valid && i_res_ready) begin
                if (expected_rects.size() == 0) begin
                    report_mismatch("result with none pending, kind", o_frame_kind, -1);
                end else begin
                    want = expected_rects.pop_front();
                    if (o_rect_left != want.left)
                        report_mismatch("rect_left", o_rect_left, want.left);
                    if (o_rect_top != want.top)
                        report_mismatch("rect_top", o_rect_top, want.top);
                    if (o_rect_right != want.right)
                        report_mismatch("rect_right", o_rect_right, want.right);
                    if (o_rect_bottom != want.bottom)
                        report_mismatch("rect_bottom", o_rect_bottom, want.bottom);
                    if (o_frame_kind != want.kind)
                        report_mismatch("frame_kind", o_frame_kind, want.kind);
                end
            end
            if (i_pix_valid && o_pix_ready) fold_pixel(i_pixel_rgb);
            pix_taken = i_pix_valid && o_pix_ready;
        end
    end

    // ---------------------------------------------------------------
    // stimulus sequence
    // ---------------------------------------------------------------
    initial begin
        int rand_pix, rand_frames, nf, n, k, w, h;
        rand_pix    = 0;
        rand_frames = 0;

        // single reset at the start of the run
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: 2x2 frames through every kind, extreme pixel values first
        write_reg(fdr_pkg::REG_FRAME_WIDTH, 2);
        write_reg(fdr_pkg::REG_FRAME_HEIGHT, 2);
        queue_frame(FR_EXTREME, 4);
        queue_frame(FR_COPY, 4);     // unchanged, shorter than the top-row band
        queue_frame(FR_ROW0, 4);     // change only in row 0 still counts
        queue_frame(FR_CORNERS, 4);  // box reaches every edge
        queue_frame(FR_ALL, 4);
        queue_frame(FR_SPARSE, 4);
        // a spare register index must not restart anything
        write_reg(REG_SPARE_2, 2047);
        queue_frame(FR_COPY, 4);

        // mid-sized frames back to back with no idling on either side
        pix_idle_pct = 0;
        res_idle_pct = 0;
        write_reg(fdr_pkg::REG_FRAME_WIDTH, 20);
        write_reg(fdr_pkg::REG_FRAME_HEIGHT, 4);
        queue_frame(FR_RANDOM, gen_w * gen_h);
        queue_frame(FR_SPARSE, gen_w * gen_h);
        queue_frame(FR_COPY, gen_w * gen_h);
        wait_idle();
        pix_idle_pct = IDLE_PCT;
        res_idle_pct = IDLE_PCT;

        // zero registers saturate to 1x1: every pixel ends a frame, so a long
        // receiver hold-off fills the result queue and stalls pixel ready
        write_reg(fdr_pkg::REG_FRAME_WIDTH, 0);
        write_reg(fdr_pkg::REG_FRAME_HEIGHT, 0);
        hold_req++;
        repeat (40) queue_frame(pick_style(), 1);

        // random phases of small frames, a few dropped part way through
        while (rand_pix < 400 || rand_frames < 16) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            write_reg(fdr_pkg::REG_FRAME_WIDTH, w);
            if (h != gen_h || $urandom_range(0, 1) == 1)
                write_reg(fdr_pkg::REG_FRAME_HEIGHT, h);
            n  = gen_w * gen_h;
            nf = $urandom_range(2, 6);
            for (int f = 0; f < nf; f++) begin
                if ($urandom_range(0, 19) == 0)
                    write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_3 : REG_SPARE_2,
                              $urandom_range(0, 2047));
                queue_frame((f == 0) ? FR_RANDOM : pick_style(), n);
                rand_pix += n;
                rand_frames++;
            end
            // broken frame: the next register write throws it away
            if ($urandom_range(0, 4) == 0 && n > 1) begin
                k = $urandom_range(1, n - 1);
                queue_frame(pick_style(), k);
                rand_pix += k;
            end
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (expected_rects.size() != 0)
            report_mismatch("results never delivered", 0, expected_rects.size());
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
